>>> rtl/telnet_client_negotiator_top_assert.svh
// Assertion macros for the telnet client negotiator top level.
// Each macro expands to one labeled concurrent assertion clocked on clk
// and disabled while rst is high.
`ifndef TELNET_CLIENT_NEGOTIATOR_TOP_ASSERT_SVH
`define TELNET_CLIENT_NEGOTIATOR_TOP_ASSERT_SVH

// Condition must hold in the same cycle as the antecedent
`define TCN_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition must hold in the cycle after the antecedent
`define TCN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tcn_pkg.sv
// ----------------------------------------------------------------------------
// tcn_pkg
// Telnet command codes, option codes, reply job types and the byte
// sequencing functions shared by the negotiator modules.
// ----------------------------------------------------------------------------
package tcn_pkg;

  // Telnet command codes
  localparam logic [7:0] CMD_IAC  = 8'd255;
  localparam logic [7:0] CMD_DONT = 8'd254;
  localparam logic [7:0] CMD_DO   = 8'd253;
  localparam logic [7:0] CMD_WONT = 8'd252;
  localparam logic [7:0] CMD_WILL = 8'd251;
  localparam logic [7:0] CMD_SB   = 8'd250;
  localparam logic [7:0] CMD_SE   = 8'd240;

  // Option codes
  localparam logic [7:0] OPT_ECHO  = 8'd1;
  localparam logic [7:0] OPT_TTYPE = 8'd24;
  localparam logic [7:0] OPT_LAST_RANGE = 8'd37;
  localparam logic [7:0] OPT_EXTRA = 8'd39;
  localparam logic [7:0] OPT_EXOPL = 8'd255;

  // Subnegotiation IS code
  localparam logic [7:0] TTYPE_IS = 8'd0;

  // Output channel codes
  localparam logic CHAN_HOST = 1'b0;
  localparam logic CHAN_PEER = 1'b1;

  // Reply lengths
  localparam logic [3:0] LEN_HOST = 4'd1;
  localparam logic [3:0] LEN_CMD3 = 4'd3;
  localparam logic [3:0] LEN_TERM = 4'd11;

  typedef enum logic [1:0] {
    JOB_NONE,
    JOB_HOST,
    JOB_CMD3,
    JOB_TERM
  } tcn_job_kind_t;

  // One decoded input byte: what it asks the emitter to send
  typedef struct packed {
    tcn_job_kind_t kind;
    logic [7:0]    cmd;
    logic [7:0]    arg;
  } tcn_job_t;

  function automatic logic [3:0] job_len(tcn_job_kind_t kind);
    logic [3:0] len;
    case (kind)
      JOB_HOST: len = LEN_HOST;
      JOB_CMD3: len = LEN_CMD3;
      JOB_TERM: len = LEN_TERM;
      default:  len = 4'd0;
    endcase
    return len;
  endfunction

  // Terminal type reply: IAC SB TTYPE IS "vt320" IAC SE
  function automatic logic [7:0] term_byte(logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = CMD_IAC;
      4'd1:    b = CMD_SB;
      4'd2:    b = OPT_TTYPE;
      4'd3:    b = TTYPE_IS;
      4'd4:    b = 8'h76;  // v
      4'd5:    b = 8'h74;  // t
      4'd6:    b = 8'h33;  // 3
      4'd7:    b = 8'h32;  // 2
      4'd8:    b = 8'h30;  // 0
      4'd9:    b = CMD_IAC;
      4'd10:   b = CMD_SE;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] emit_byte(tcn_job_t job, logic [3:0] idx);
    logic [7:0] b;
    case (job.kind)
      JOB_HOST: b = job.arg;
      JOB_CMD3: begin
        if (idx == 4'd0) begin
          b = CMD_IAC;
        end else if (idx == 4'd1) begin
          b = job.cmd;
        end else begin
          b = job.arg;
        end
      end
      JOB_TERM: b = term_byte(idx);
      default:  b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/tcn_rx_if.sv
// ----------------------------------------------------------------------------
// tcn_rx_if
// Valid/ready channel carrying one received telnet byte per transfer.
// ----------------------------------------------------------------------------
interface tcn_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

>>> rtl/tcn_res_if.sv
// ----------------------------------------------------------------------------
// tcn_res_if
// Valid/ready channel carrying one result byte per transfer, tagged with
// its channel and an end-of-item mark.
// ----------------------------------------------------------------------------
interface tcn_res_if;
  logic       valid;
  logic       ready;
  logic       channel;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output channel, output out_byte, output last, input ready);
  modport sink (input valid, input channel, input out_byte, input last, output ready);
endinterface

>>> rtl/tcn_parser.sv
// ----------------------------------------------------------------------------
// tcn_parser
// Telnet stream parser: holds the parse mode, last command and echo flag,
// and decodes the current byte into a reply job. State advances on take.
// ----------------------------------------------------------------------------
module tcn_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       rx_byte,
  input  logic             take,
  output tcn_pkg::tcn_job_t job
);

  typedef enum logic [1:0] {
    MODE_DATA,
    MODE_CMD,
    MODE_OPT,
    MODE_SKIP
  } mode_t;

  mode_t      mode;
  mode_t      mode_next;
  logic [7:0] held_cmd;
  logic [7:0] held_cmd_next;
  logic       echo_on;
  logic       echo_on_next;
  logic       listed;

  // Options refused when offered or requested
  assign listed = ((rx_byte <= tcn_pkg::OPT_LAST_RANGE) &&
                   (rx_byte != tcn_pkg::OPT_ECHO) &&
                   (rx_byte != tcn_pkg::OPT_TTYPE)) ||
                  (rx_byte == tcn_pkg::OPT_EXTRA) ||
                  (rx_byte == tcn_pkg::OPT_EXOPL);

  // Decode the byte against the current mode
  always_comb begin
    mode_next     = mode;
    held_cmd_next = held_cmd;
    echo_on_next  = echo_on;
    job.kind      = tcn_pkg::JOB_NONE;
    job.cmd       = 8'd0;
    job.arg       = rx_byte;
    case (mode)
      MODE_DATA: begin
        if (rx_byte == tcn_pkg::CMD_IAC) begin
          mode_next = MODE_CMD;
        end else if (echo_on) begin
          job.kind = tcn_pkg::JOB_HOST;
        end
      end
      MODE_CMD: begin
        held_cmd_next = rx_byte;
        if (rx_byte inside {[tcn_pkg::CMD_SB:tcn_pkg::CMD_DONT]}) begin
          mode_next = MODE_OPT;
        end else begin
          mode_next = MODE_DATA;
        end
      end
      MODE_OPT: begin
        mode_next = (held_cmd == tcn_pkg::CMD_SB) ? MODE_SKIP : MODE_DATA;
        if (rx_byte == tcn_pkg::OPT_ECHO) begin
          if (held_cmd == tcn_pkg::CMD_WILL) begin
            echo_on_next = 1'b1;
            job.kind     = tcn_pkg::JOB_CMD3;
            job.cmd      = tcn_pkg::CMD_DO;
          end else if (held_cmd == tcn_pkg::CMD_WONT) begin
            echo_on_next = 1'b0;
            job.kind     = tcn_pkg::JOB_CMD3;
            job.cmd      = tcn_pkg::CMD_DONT;
          end else if (held_cmd == tcn_pkg::CMD_DO || held_cmd == tcn_pkg::CMD_DONT) begin
            job.kind = tcn_pkg::JOB_CMD3;
            job.cmd  = tcn_pkg::CMD_WONT;
          end
        end else if (rx_byte == tcn_pkg::OPT_TTYPE) begin
          if (held_cmd == tcn_pkg::CMD_SB) begin
            job.kind = tcn_pkg::JOB_TERM;
          end else if (held_cmd == tcn_pkg::CMD_WILL) begin
            job.kind = tcn_pkg::JOB_CMD3;
            job.cmd  = tcn_pkg::CMD_DONT;
          end else if (held_cmd == tcn_pkg::CMD_DO) begin
            job.kind = tcn_pkg::JOB_CMD3;
            job.cmd  = tcn_pkg::CMD_WILL;
          end
        end else if (listed) begin
          if (held_cmd == tcn_pkg::CMD_WILL) begin
            job.kind = tcn_pkg::JOB_CMD3;
            job.cmd  = tcn_pkg::CMD_DONT;
          end else if (held_cmd == tcn_pkg::CMD_DO) begin
            job.kind = tcn_pkg::JOB_CMD3;
            job.cmd  = tcn_pkg::CMD_WONT;
          end
        end
      end
      MODE_SKIP: begin
        if (rx_byte == tcn_pkg::CMD_IAC) begin
          mode_next = MODE_CMD;
        end
      end
      default: begin
        mode_next = MODE_DATA;
      end
    endcase
  end

  // Advance the parse state when the emitter takes the byte
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_DATA;
      held_cmd <= tcn_pkg::CMD_SB;
      echo_on  <= 1'b1;
    end else if (take) begin
      mode     <= mode_next;
      held_cmd <= held_cmd_next;
      echo_on  <= echo_on_next;
    end
  end

endmodule

>>> rtl/tcn_emitter.sv
// ----------------------------------------------------------------------------
// tcn_emitter
// Holds one reply job and steps through its bytes into the result
// register, one byte per cycle unless the receiver holds off, marking the final byte of each job.
// ----------------------------------------------------------------------------
module tcn_emitter (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  tcn_pkg::tcn_job_t job,
  output logic              take,
  tcn_res_if.source         res
);

  logic              j_valid;
  tcn_pkg::tcn_job_t j_job;
  logic [3:0]        j_idx;
  logic              j_final;
  logic              out_load;
  logic              job_free;
  logic              load_job;
  logic              o_valid;
  logic              o_channel;
  logic [7:0]        o_byte;
  logic              o_last;

  // Byte step and handoff
  assign j_final  = (j_idx == (tcn_pkg::job_len(j_job.kind) - 4'd1));
  assign out_load = j_valid && (!o_valid || res.ready);
  assign job_free = !j_valid || (out_load && j_final);
  assign take     = job_valid && ((job.kind == tcn_pkg::JOB_NONE) || job_free);
  assign load_job = take && (job.kind != tcn_pkg::JOB_NONE);

  // Hold the job and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      j_valid <= 1'b0;
      j_idx   <= 4'd0;
      o_valid <= 1'b0;
    end else begin
      if (load_job) begin
        j_valid <= 1'b1;
        j_idx   <= 4'd0;
      end else if (out_load) begin
        if (j_final) begin
          j_valid <= 1'b0;
        end else begin
          j_idx <= j_idx + 4'd1;
        end
      end
      if (out_load) begin
        o_valid <= 1'b1;
      end else if (o_valid && res.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // Result payload and job payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      o_channel <= (j_job.kind == tcn_pkg::JOB_HOST) ? tcn_pkg::CHAN_HOST : tcn_pkg::CHAN_PEER;
      o_byte    <= tcn_pkg::emit_byte(j_job, j_idx);
      o_last    <= j_final;
    end
    if (load_job) begin
      j_job <= job;
    end
  end

  assign res.valid    = o_valid;
  assign res.channel  = o_channel;
  assign res.out_byte = o_byte;
  assign res.last     = o_last;

endmodule

>>> rtl/telnet_client_negotiator_top.sv
// ----------------------------------------------------------------------------
// telnet_client_negotiator_top
// Telnet receive-side option negotiator with host data and peer reply output.
// ----------------------------------------------------------------------------
// Received bytes enter an input register, are parsed against the telnet
// state (data, command, option, skipped subnegotiation) and turn into zero
// or more result bytes: plain data for the host while echo is on, or reply
// bytes for the peer. A byte that yields zero or one result is taken every
// cycle while the emitter is free; a 3-byte option reply and the 11-byte
// terminal type reply hold the input while the single result register
// sends their bytes, one per cycle unless the receiver holds off. The last
// flag marks the final result of each received byte.
module telnet_client_negotiator_top (
  input  logic      clk,
  input  logic      rst,
  tcn_rx_if.sink    rx,
  tcn_res_if.source res
);

  `include "telnet_client_negotiator_top_assert.svh"

  logic              a_valid;
  logic [7:0]        a_byte;
  logic              take;
  tcn_pkg::tcn_job_t job;

  // Input register: accept when empty or when its byte moves on
  assign rx.ready = !a_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      a_valid <= 1'b1;
    end else if (take) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      a_byte <= rx.rx_byte;
    end
  end

  tcn_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .rx_byte (a_byte),
    .take    (take),
    .job     (job)
  );

  tcn_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .job_valid (a_valid),
    .job       (job),
    .take      (take),
    .res       (res)
  );

  // Checks
  `TCN_ASSERT_NEXT(a_hold_chk, a_valid && !take, a_valid && $stable(a_byte), "input byte lost while waiting")
  `TCN_ASSERT_IMPLY(a_ready_chk, !a_valid, rx.ready, "empty input register refuses a transfer")
  `TCN_ASSERT_IMPLY(host_last_chk, res.valid && (res.channel == tcn_pkg::CHAN_HOST), res.last, "host byte not marked last")

endmodule

>>> dv/tb_telnet_client_negotiator_top.sv
// ----------------------------------------------------------------------------
// tb_telnet_client_negotiator_top
// Self-checking bench for the telnet option negotiator. Received bytes go in
// over the rx channel. A behavioral parser in the bench tracks the telnet
// state and builds the expected host data and peer reply bytes. Each result
// transfer is checked in order against that list. Both sides idle at random.
// The receiver holds off once so that the input stalls, and the sender twice
// waits for all replies before going on.
// ----------------------------------------------------------------------------
module tb_telnet_client_negotiator_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES  = 120;
  localparam int FLUSH_CYCLES = 10;

  // Terminal type answer: IAC SB TTYPE IS "vt320" IAC SE, first byte on top
  localparam logic [87:0] TTYPE_ANSWER = {tcn_pkg::CMD_IAC, tcn_pkg::CMD_SB,
                                          tcn_pkg::OPT_TTYPE, tcn_pkg::TTYPE_IS,
                                          "vt320", tcn_pkg::CMD_IAC, tcn_pkg::CMD_SE};

  typedef enum logic [1:0] {
    PM_DATA,
    PM_CMD,
    PM_OPT,
    PM_SKIP
  } parse_mode_t;

  typedef struct packed {
    logic       channel;
    logic [7:0] out_byte;
    logic       last;
  } res_byte_t;

  logic clk;
  logic rst;

  tcn_rx_if  rx_ch ();
  tcn_res_if res_ch ();

  telnet_client_negotiator_top dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .res (res_ch)
  );

  // Parser state mirrored in the bench
  parse_mode_t mode;
  logic [7:0]  held_cmd;
  logic        echo_en;

  res_byte_t   pending_bytes[$];
  int          mismatches;
  int          sent_items;
  bit          no_idle;
  bit          hold_req;

  // Clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Queue one expected result byte
  function automatic void queue_byte(input logic chan, input logic [7:0] b);
    res_byte_t r;
    r.channel  = chan;
    r.out_byte = b;
    r.last     = 1'b0;
    pending_bytes = {pending_bytes, r};
  endfunction

  function automatic void queue_cmd3(input logic [7:0] cmd, input logic [7:0] opt);
    queue_byte(tcn_pkg::CHAN_PEER, tcn_pkg::CMD_IAC);
    queue_byte(tcn_pkg::CHAN_PEER, cmd);
    queue_byte(tcn_pkg::CHAN_PEER, opt);
  endfunction

  // Reply to the option byte that follows the held command
  function automatic void answer_option(input logic [7:0] opt);
    int i;
    if (opt == tcn_pkg::OPT_ECHO) begin
      if (held_cmd == tcn_pkg::CMD_WILL) begin
        echo_en = 1'b1;
        queue_cmd3(tcn_pkg::CMD_DO, opt);
      end else if (held_cmd == tcn_pkg::CMD_WONT) begin
        echo_en = 1'b0;
        queue_cmd3(tcn_pkg::CMD_DONT, opt);
      end else if (held_cmd == tcn_pkg::CMD_DO || held_cmd == tcn_pkg::CMD_DONT) begin
        queue_cmd3(tcn_pkg::CMD_WONT, opt);
      end
    end else if (opt == tcn_pkg::OPT_TTYPE) begin
      if (held_cmd == tcn_pkg::CMD_SB) begin
        for (i = 0; i < 11; i++) begin
          queue_byte(tcn_pkg::CHAN_PEER, TTYPE_ANSWER[87 - 8 * i -: 8]);
        end
      end else if (held_cmd == tcn_pkg::CMD_WILL) begin
        queue_cmd3(tcn_pkg::CMD_DONT, opt);
      end else if (held_cmd == tcn_pkg::CMD_DO) begin
        queue_cmd3(tcn_pkg::CMD_WILL, opt);
      end
    end else if (opt <= tcn_pkg::OPT_LAST_RANGE || opt == tcn_pkg::OPT_EXTRA ||
                 opt == tcn_pkg::OPT_EXOPL) begin
      // Known option we do not support: refuse offers and requests
      if (held_cmd == tcn_pkg::CMD_WILL) begin
        queue_cmd3(tcn_pkg::CMD_DONT, opt);
      end else if (held_cmd == tcn_pkg::CMD_DO) begin
        queue_cmd3(tcn_pkg::CMD_WONT, opt);
      end
    end
  endfunction

  // Advance the parser by one received byte and queue what it emits
  function automatic void parse_rx_byte(input logic [7:0] b);
    int unsigned base;
    base = pending_bytes.size();
    case (mode)
      PM_DATA: begin
        if (b == tcn_pkg::CMD_IAC) begin
          mode = PM_CMD;
        end else if (echo_en) begin
          queue_byte(tcn_pkg::CHAN_HOST, b);
        end
      end
      PM_CMD: begin
        held_cmd = b;
        mode = (b >= tcn_pkg::CMD_SB && b <= tcn_pkg::CMD_DONT) ? PM_OPT : PM_DATA;
      end
      PM_OPT: begin
        answer_option(b);
        mode = (held_cmd == tcn_pkg::CMD_SB) ? PM_SKIP : PM_DATA;
      end
      default: begin
        if (b == tcn_pkg::CMD_IAC) mode = PM_CMD;
      end
    endcase
    // Mark the final byte caused by this input
    if (pending_bytes.size() > base) begin
      pending_bytes[pending_bytes.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  // Predict on every input transfer, check every result transfer
  always @(posedge clk) begin
    res_byte_t want;
    if (!rst) begin
      if (rx_ch.valid && rx_ch.ready) parse_rx_byte(rx_ch.rx_byte);
      if (res_ch.valid && res_ch.ready) begin
        if (pending_bytes.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual ch=%0d byte=%02h last=%0d",
                   $time, res_ch.channel, res_ch.out_byte, res_ch.last);
          mismatches++;
        end else begin
          want = pending_bytes.pop_front();
          check_field("channel", want.channel, res_ch.channel);
          check_field("out_byte", want.out_byte, res_ch.out_byte);
          check_field("last", want.last, res_ch.last);
        end
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    res_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 17);
      end
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
    end
  end

  // Offer one byte after a random gap and hold it until the transfer
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    sent_items++;
  endtask

  task automatic send_cmd3(input logic [7:0] cmd, input logic [7:0] opt);
    send_byte(tcn_pkg::CMD_IAC);
    send_byte(cmd);
    send_byte(opt);
  endtask

  // Drop valid and wait until every expected result has arrived
  task automatic wait_for_drain();
    rx_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_bytes.size() != 0);
  endtask

  // One random sequence: well-formed negotiation most often, else data or noise
  task automatic send_random_burst();
    int         pick;
    int         n;
    logic [7:0] cmd;
    logic [7:0] opt;
    no_idle = ($urandom_range(0, 5) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      n = $urandom_range(1, 4);
      repeat (n) send_byte(8'($urandom_range(0, 254)));
    end else if (pick < 80) begin
      cmd = 8'($urandom_range(tcn_pkg::CMD_SB, tcn_pkg::CMD_DONT));
      case ($urandom_range(0, 3))
        0:       opt = tcn_pkg::OPT_ECHO;
        1:       opt = tcn_pkg::OPT_TTYPE;
        default: opt = 8'($urandom_range(0, 255));
      endcase
      send_cmd3(cmd, opt);
      if (cmd == tcn_pkg::CMD_SB) begin
        n = $urandom_range(0, 3);
        repeat (n) send_byte(8'($urandom_range(0, 254)));
        // Leave the subnegotiation open now and then
        if ($urandom_range(0, 9) != 0) begin
          send_byte(tcn_pkg::CMD_IAC);
          send_byte(tcn_pkg::CMD_SE);
        end
      end
    end else if (pick < 90) begin
      send_byte(tcn_pkg::CMD_IAC);
      send_byte(8'($urandom_range(0, 255)));
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Data bytes, doubled IAC and the echo switch
  task automatic test_data_and_echo();
    send_byte(8'h00);
    send_byte(8'hFE);
    send_byte(tcn_pkg::CMD_IAC);
    send_byte(tcn_pkg::CMD_IAC);
    send_cmd3(tcn_pkg::CMD_WONT, tcn_pkg::OPT_ECHO);
    send_byte(8'h41);
    send_cmd3(tcn_pkg::CMD_DO, tcn_pkg::OPT_ECHO);
    send_cmd3(tcn_pkg::CMD_DONT, tcn_pkg::OPT_ECHO);
    send_cmd3(tcn_pkg::CMD_WILL, tcn_pkg::OPT_ECHO);
  endtask

  // Terminal type, refused and unknown options, skipped subnegotiation
  task automatic test_option_replies();
    send_cmd3(tcn_pkg::CMD_SB, tcn_pkg::OPT_TTYPE);
    send_byte(8'h55);
    send_byte(tcn_pkg::CMD_IAC);
    send_byte(tcn_pkg::CMD_SE);
    send_cmd3(tcn_pkg::CMD_WILL, tcn_pkg::OPT_TTYPE);
    send_cmd3(tcn_pkg::CMD_DO, tcn_pkg::OPT_EXOPL);
    send_cmd3(tcn_pkg::CMD_WILL, 8'd38);
  endtask

  task automatic test_random_traffic(input int target);
    while (sent_items < target) send_random_burst();
  endtask

  // Receiver holds off while the sender keeps offering long replies
  task automatic test_receiver_holdoff();
    wait_for_drain();
    no_idle  = 1'b1;
    hold_req = 1'b1;
    send_cmd3(tcn_pkg::CMD_WILL, tcn_pkg::OPT_ECHO);
    repeat (3) begin
      send_cmd3(tcn_pkg::CMD_SB, tcn_pkg::OPT_TTYPE);
      send_byte(tcn_pkg::CMD_IAC);
      send_byte(tcn_pkg::CMD_SE);
    end
    send_cmd3(tcn_pkg::CMD_DO, 8'd5);
    send_byte(8'h7A);
    send_byte(8'h80);
    no_idle = 1'b0;
  endtask

  // Sender pauses mid-stream until every reply is out
  task automatic test_sender_pause(input int target);
    test_random_traffic(sent_items + (target - sent_items) / 2);
    wait_for_drain();
    test_random_traffic(target);
  endtask

  // Test sequence
  initial begin
    mode          = PM_DATA;
    held_cmd      = tcn_pkg::CMD_SB;
    echo_en       = 1'b1;
    mismatches    = 0;
    sent_items    = 0;
    no_idle       = 1'b0;
    hold_req      = 1'b0;
    rst           <= 1'b1;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= 8'h00;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_data_and_echo();
    test_option_replies();
    test_random_traffic(150);
    test_receiver_holdoff();
    test_sender_pause(210);

    wait_for_drain();
    repeat (FLUSH_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Timeout
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
